[rtl/tla_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tla_pkg
// Shared types and constants for the tolerant lexicographic argmin block.
// ----------------------------------------------------------------------------
package tla_pkg;

	localparam int unsigned MAX_ENTRIES = 256;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned OUT_IDX_W = 8;
	localparam int unsigned CFG_IDX_W = 1;

	// select_mode codes; the unused code falls back to minimax
	localparam logic [1:0] MODE_MINIMAX = 2'd0;
	localparam logic [1:0] MODE_LEAST_B = 2'd1;
	localparam logic [1:0] MODE_LEAST_V = 2'd2;
	localparam logic [1:0] MODE_UNUSED  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 1'd1;

	localparam logic [1:0]        MODE_RESET = MODE_MINIMAX;
	localparam logic [WORD_W-1:0] TOL_RESET  = 32'd6554;

	// one stored candidate, value in the low bits
	typedef struct packed {
		logic [WORD_W-1:0] cost_v;
		logic [WORD_W-1:0] cost_b;
		logic [WORD_W-1:0] grid_value;
	} entry_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] index;
		logic [WORD_W-1:0]    value;
	} result_t;

endpackage
`default_nettype wire

[rtl/tla_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tla_store
// Candidate memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tla_store #(
	parameter int unsigned DEPTH = tla_pkg::MAX_ENTRIES,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                  clk,
	input  wire                  wr_en,
	input  wire [AW-1:0]         wr_addr,
	input  tla_pkg::entry_t      wr_data,
	input  wire                  rd_en,
	input  wire [AW-1:0]         rd_addr,
	output tla_pkg::entry_t      rd_data
);

	tla_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[rtl/tla_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tla_scan
// Selection sequencer: walks the stored set once or twice through one
// shared compare unit and holds the running best entry.
// ----------------------------------------------------------------------------
module tla_scan #(
	parameter int unsigned MAX_ENTRIES = tla_pkg::MAX_ENTRIES,
	parameter int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	parameter int unsigned CNT_W = $clog2(MAX_ENTRIES + 1)
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [CNT_W-1:0]              count,
	input  wire [1:0]                    mode,
	input  wire [tla_pkg::WORD_W-1:0]    tolerance,
	output logic                         rd_en,
	output logic [IDX_W-1:0]             rd_addr,
	input  tla_pkg::entry_t              rd_data,
	input  wire                          res_free,
	output logic                         busy,
	output logic                         done,
	output tla_pkg::result_t             res
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PASS1 = 3'd1;
	localparam logic [2:0] S_LIMIT = 3'd2;
	localparam logic [2:0] S_PASS2 = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	localparam int unsigned W = tla_pkg::WORD_W;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              d_valid_s1;
	logic              d_last_s1;
	logic [IDX_W-1:0]  d_idx_s1;
	logic              found_q;
	logic [W-1:0]      best_key_q;
	logic [W-1:0]      best_val_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [W:0]        limit_q;

	logic              in_pass;
	logic              tolerant;
	logic [W-1:0]      gate;
	logic [W-1:0]      rank;
	logic [W-1:0]      key;
	logic              qual;
	logic              better;
	logic              pass_end;
	logic [IDX_W+7:0]  idx_ext;

	assign in_pass  = (state_q == S_PASS1) || (state_q == S_PASS2);
	assign tolerant = mode inside {tla_pkg::MODE_LEAST_B, tla_pkg::MODE_LEAST_V};
	assign rd_en    = in_pass && (ptr_q < count);
	assign rd_addr  = ptr_q[IDX_W-1:0];
	assign busy     = (state_q != S_IDLE);
	assign done     = (state_q == S_DONE) && res_free;
	assign pass_end = d_valid_s1 && d_last_s1;

	// pass 2 tests gate cost against the limit, minimizes rank cost
	always_comb begin
		if (mode == tla_pkg::MODE_LEAST_B) begin
			gate = rd_data.cost_v;
			rank = rd_data.cost_b;
		end else begin
			gate = rd_data.cost_b;
			rank = rd_data.cost_v;
		end
		if (state_q == S_PASS2) begin
			key  = rank;
			qual = ({1'b0, gate} <= limit_q);
		end else begin
			qual = 1'b1;
			if (tolerant) begin
				key = gate;
			end else begin
				key = (rd_data.cost_b > rd_data.cost_v) ? rd_data.cost_b : rd_data.cost_v;
			end
		end
		better = d_valid_s1 && qual && (!found_q || (key < best_key_q));
	end

	assign idx_ext   = {8'd0, best_idx_q};
	assign res.value = best_val_q;
	assign res.index = idx_ext[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ptr_q      <= '0;
			d_valid_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			d_valid_s1 <= rd_en;
			if (rd_en) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (better) begin
				found_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_PASS1;
						ptr_q   <= '0;
						found_q <= 1'b0;
					end
				end
				S_PASS1: begin
					if (pass_end) begin
						state_q <= tolerant ? S_LIMIT : S_DONE;
					end
				end
				S_LIMIT: begin
					state_q <= S_PASS2;
					ptr_q   <= '0;
					found_q <= 1'b0;
				end
				S_PASS2: begin
					if (pass_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: read tag pipeline, running best and the tolerance limit
	always_ff @(posedge clk) begin
		d_idx_s1  <= ptr_q[IDX_W-1:0];
		d_last_s1 <= (ptr_q == count - CNT_W'(1));
		if (better) begin
			best_key_q <= key;
			best_val_q <= rd_data.grid_value;
			best_idx_q <= d_idx_s1;
		end
		if (state_q == S_LIMIT) begin
			limit_q <= {1'b0, best_key_q} + {1'b0, tolerance};
		end
	end

endmodule
`default_nettype wire

[rtl/tolerant_lexicographic_argmin.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tolerant_lexicographic_argmin
// Loads a set of candidates and picks one by minimax or by a tolerant
// two-cost ranking.
//
//   channel   dir  handshake          payload
//   s_*       in   tvalid/tready      tdata {cost_v, cost_b, grid_value}, tlast
//   m_*       out  tvalid/tready      tdata {chosen_index, chosen_value}, tuser
//   cfg_*     in   cfg_we             cfg_index, cfg_data
//
// Loading takes one word per cycle while s_tready is high. After the tlast
// word, s_tready drops for the selection, in which the single memory read
// port walks the stored set once in minimax mode and twice in the tolerance
// modes. The result sits in an output register; the block waits in its last
// state only if that register is still full. Reset leaves the set empty and
// the registers at their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tolerant_lexicographic_argmin #(
	parameter int unsigned MAX_ENTRIES = tla_pkg::MAX_ENTRIES
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [95:0]                         s_tdata,  // grid_value, cost_b, cost_v
	input  wire                                s_tlast,  // final_entry
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [39:0]                        m_tdata,  // chosen_value, chosen_index
	output logic                               m_tuser,  // overflowed
	input  wire                                cfg_we,
	input  wire [tla_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [tla_pkg::WORD_W-1:0]          cfg_data
);

	localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

	logic [1:0]                  mode_q;
	logic [tla_pkg::WORD_W-1:0]  tol_q;
	logic [CNT_W-1:0]            count_q;
	logic                        drop_q;
	logic                        m_valid_q;
	tla_pkg::result_t            m_res_q;
	logic                        m_drop_q;

	logic                        accept;
	logic                        room;
	logic                        start;
	logic                        res_free;
	logic                        scan_busy;
	logic                        scan_done;
	tla_pkg::result_t            scan_res;
	logic                        rd_en;
	logic [IDX_W-1:0]            rd_addr;
	tla_pkg::entry_t             rd_data;
	tla_pkg::entry_t             wr_data;

	assign s_tready = !scan_busy;
	assign accept   = s_tvalid && s_tready;
	assign room     = (count_q < CNT_W'(MAX_ENTRIES));
	assign start    = accept && s_tlast;
	assign res_free = !m_valid_q || m_tready;
	assign wr_data  = tla_pkg::entry_t'(s_tdata);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_res_q;
	assign m_tuser  = m_drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= tla_pkg::MODE_RESET;
			tol_q     <= tla_pkg::TOL_RESET;
			count_q   <= '0;
			drop_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tla_pkg::REG_SELECT_MODE: mode_q <= cfg_data[1:0];
					tla_pkg::REG_TOLERANCE:   tol_q  <= cfg_data;
					default: ;
				endcase
			end
			// drop words that arrive with the store full
			if (accept) begin
				if (room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (scan_done) begin
				count_q   <= '0;
				drop_q    <= 1'b0;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_done) begin
			m_res_q  <= scan_res;
			m_drop_q <= drop_q;
		end
	end

	tla_store #(
		.DEPTH (MAX_ENTRIES),
		.AW    (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (accept && room),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tla_scan #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.count     (count_q),
		.mode      (mode_q),
		.tolerance (tol_q),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res_free  (res_free),
		.busy      (scan_busy),
		.done      (scan_done),
		.res       (scan_res)
	);

endmodule
`default_nettype wire

[rtl/tla_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tla_checker
// Port-level checks for the argmin block, bound to its top level.
// ----------------------------------------------------------------------------
module tla_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        s_tlast,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire        m_tuser
);

	// a closing word starts the selection, so input stalls next cycle
	a_stall_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input still ready after closing word");

	// input only stalls because a set was closed
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid && s_tlast))
		else $error("input stalled without a closing word");

	// a new result comes only out of a selection run
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a selection run");

	// hold the result word until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result word changed while stalled");

endmodule

bind tolerant_lexicographic_argmin tla_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

[test/argmin_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argmin_checker
// Watches the candidate, result and register channels of the argmin block,
// keeps its own copy of the loaded set and the registers, works out the chosen
// entry when a set closes, and compares every result word field by field.
// ----------------------------------------------------------------------------
module argmin_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire [95:0]  s_tdata,   // grid_value, cost_b, cost_v
	input  wire         s_tlast,   // final_entry
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire [39:0]  m_tdata,   // chosen_value, chosen_index
	input  wire         m_tuser,   // overflowed
	input  wire         cfg_we,
	input  wire [tla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [tla_pkg::WORD_W-1:0]    cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0] value;
		logic [7:0]  index;
		logic        overflowed;
	} choice_t;

	logic [31:0] held_value [tla_pkg::MAX_ENTRIES];
	logic [31:0] held_b [tla_pkg::MAX_ENTRIES];
	logic [31:0] held_v [tla_pkg::MAX_ENTRIES];
	int unsigned held_count;
	bit          dropped;
	logic [1:0]  mode_r;
	logic [31:0] tol_r;
	choice_t     choice_q[$];

	function automatic int unsigned pick_entry();
		logic [31:0] gate;
		logic [31:0] rank;
		logic [31:0] low_gate;
		logic [31:0] best;
		logic [32:0] limit;
		int unsigned best_i;
		bit          found;
		best_i = 0;
		best = '0;
		found = 1'b0;
		if (mode_r inside {tla_pkg::MODE_LEAST_B, tla_pkg::MODE_LEAST_V}) begin
			low_gate = '1;
			for (int unsigned i = 0; i < held_count; i++) begin
				gate = (mode_r == tla_pkg::MODE_LEAST_B) ? held_v[i] : held_b[i];
				if (gate < low_gate)
					low_gate = gate;
			end
			// 33-bit sum, the slack never wraps
			limit = {1'b0, low_gate} + {1'b0, tol_r};
			for (int unsigned i = 0; i < held_count; i++) begin
				gate = (mode_r == tla_pkg::MODE_LEAST_B) ? held_v[i] : held_b[i];
				rank = (mode_r == tla_pkg::MODE_LEAST_B) ? held_b[i] : held_v[i];
				if ({1'b0, gate} <= limit && (!found || rank < best)) begin
					best = rank;
					best_i = i;
					found = 1'b1;
				end
			end
		end else begin
			for (int unsigned i = 0; i < held_count; i++) begin
				rank = (held_b[i] > held_v[i]) ? held_b[i] : held_v[i];
				if (i == 0 || rank < best) begin
					best = rank;
					best_i = i;
				end
			end
		end
		return best_i;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		choice_t     want;
		choice_t     got;
		int unsigned sel;
		if (!arst_n) begin
			held_count = 0;
			dropped = 1'b0;
			mode_r = tla_pkg::MODE_RESET;
			tol_r = tla_pkg::TOL_RESET;
			choice_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tla_pkg::REG_SELECT_MODE: mode_r = cfg_data[1:0];
					tla_pkg::REG_TOLERANCE:   tol_r = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.value = m_tdata[31:0];
				got.index = m_tdata[39:32];
				got.overflowed = m_tuser;
				if (choice_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t argmin_checker: unexpected result %s",
							$time, $sformatf("value %h index %0d ovf %0b",
							got.value, got.index, got.overflowed));
					fail_count++;
				end else begin
					want = choice_q.pop_front();
					if (got.value !== want.value || got.index !== want.index ||
							got.overflowed !== want.overflowed) begin
						if (fail_count < 10)
							$display("%0t argmin_checker: expected %s, got %s", $time,
								$sformatf("value %h index %0d ovf %0b",
								want.value, want.index, want.overflowed),
								$sformatf("value %h index %0d ovf %0b",
								got.value, got.index, got.overflowed));
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (held_count < tla_pkg::MAX_ENTRIES) begin
					held_value[held_count] = s_tdata[31:0];
					held_b[held_count] = s_tdata[63:32];
					held_v[held_count] = s_tdata[95:64];
					held_count++;
				end else begin
					dropped = 1'b1;
				end
				// a dropped final word still closes the set
				if (s_tlast) begin
					sel = pick_entry();
					want.value = held_value[sel];
					want.index = sel[7:0];
					want.overflowed = dropped;
					choice_q.push_back(want);
					held_count = 0;
					dropped = 1'b0;
				end
			end
			pending = choice_q.size();
		end
	end

endmodule

[test/tolerant_lexicographic_argmin_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolerant_lexicographic_argmin_tb
// Drives candidate sets through the argmin block in every selection mode and
// over a range of tolerances, with bursty input and a stalling result side.
// A directed part covers ties, tolerance edges, the slack sum near the top of
// the range and the unused mode; the random part adds sets of mixed sizes,
// one full set and one that overflows. The checker does the comparison.
// ----------------------------------------------------------------------------
module tolerant_lexicographic_argmin_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [95:0] s_tdata = '0;   // grid_value, cost_b, cost_v
	logic        s_tlast = 1'b0; // final_entry
	wire         m_tvalid;
	logic        m_tready = 1'b1;
	wire  [39:0] m_tdata;        // chosen_value, chosen_index
	wire         m_tuser;        // overflowed
	logic        cfg_we = 1'b0;
	logic [tla_pkg::CFG_IDX_W-1:0] cfg_index = tla_pkg::REG_SELECT_MODE;
	logic [tla_pkg::WORD_W-1:0]    cfg_data = '0;

	int          fail_count;
	int          pending;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	int unsigned gap_level = 0;
	int unsigned stall_level = 0;
	int unsigned hold_left = 0;

	tolerant_lexicographic_argmin uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	argmin_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: alternate ready and stall runs, stall run lengths set by stall_level
	always @(posedge clk) begin
		if (stall_level == 0) begin
			m_tready <= 1'b1;
		end else if (hold_left == 0) begin
			if (m_tready) begin
				m_tready <= 1'b0;
				hold_left = $urandom_range(1, 4 * stall_level);
			end else begin
				m_tready <= 1'b1;
				hold_left = $urandom_range(1, 6);
			end
		end else begin
			hold_left--;
		end
	end

	task automatic push_entry(input logic [31:0] gv, input logic [31:0] b,
			input logic [31:0] v, input logic last);
		int unsigned gap;
		if (gap_level != 0 && burst_left == 0) begin
			gap = $urandom_range(0, 2 * gap_level);
			burst_left = $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {v, b, gv};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		if (burst_left > 0)
			burst_left--;
		items_sent++;
	endtask

	// hold off until every result is back and the block is idle
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tla_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [1:0] mode, input logic [31:0] tol);
		logic [31:0] word;
		drain();
		word = $urandom;
		word[1:0] = mode;
		write_reg(tla_pkg::REG_SELECT_MODE, word);
		write_reg(tla_pkg::REG_TOLERANCE, tol);
	endtask

	function automatic logic [31:0] draw_cost(input int unsigned style,
			input logic [31:0] base);
		case (style)
			0: return $urandom_range(0, 3);
			1: return $urandom_range(0, 1000);
			2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			3: return base + $urandom_range(0, 20000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] draw_tolerance();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return tla_pkg::TOL_RESET;
			2: return $urandom_range(0, 64);
			3: return $urandom_range(0, 40000);
			4: return $urandom;
			default: return '1;
		endcase
	endfunction

	// best_last: every entry but the last gets nonzero costs, the last gets zero
	task automatic send_set(input int unsigned count, input bit best_last);
		int unsigned set_style;
		int unsigned style;
		logic [31:0] base;
		logic [31:0] b;
		logic [31:0] v;
		set_style = $urandom_range(0, 6);
		base = $urandom;
		for (int unsigned i = 0; i < count; i++) begin
			style = (set_style < 5) ? set_style : $urandom_range(0, 4);
			b = draw_cost(style, base);
			v = draw_cost(style, base);
			if (best_last) begin
				b = (i == count - 1) ? '0 : (b | 32'd1);
				v = (i == count - 1) ? '0 : (v | 32'd1);
			end
			push_entry($urandom, b, v, i == count - 1);
		end
	endtask

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int unsigned phase;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: minimax, tie on max(B,V) goes to the earliest
		push_entry(32'h7FFF_FFFF, 32'd5, 32'd9, 1'b0);
		push_entry(32'h8000_0000, 32'd9, 32'd5, 1'b0);
		push_entry(32'h0000_0000, 32'hFFFF_FFFF, 32'd0, 1'b1);
		// single entry at the top of every field
		push_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

		// least B near min V, zero slack
		set_regs(tla_pkg::MODE_LEAST_B, 32'd0);
		push_entry(32'h0001_0000, 32'd7, 32'd10, 1'b0);
		push_entry(32'hFFFF_0000, 32'd3, 32'd10, 1'b0);
		push_entry(32'h1234_5678, 32'd1, 32'd11, 1'b1);

		// entry exactly at min + tolerance qualifies, one past does not
		set_regs(tla_pkg::MODE_LEAST_B, 32'd5);
		push_entry(32'h0000_0001, 32'd9, 32'd10, 1'b0);
		push_entry(32'h0000_0002, 32'd8, 32'd15, 1'b0);
		push_entry(32'h0000_0003, 32'd7, 32'd16, 1'b1);

		// least V near min B with the slack sum past 32 bits
		set_regs(tla_pkg::MODE_LEAST_V, 32'hFFFF_FFFF);
		push_entry(32'hDEAD_BEEF, 32'hFFFF_FFFE, 32'd4, 1'b0);
		push_entry(32'h2152_4110, 32'hFFFF_FFFF, 32'd2, 1'b1);

		// unused mode code falls back to minimax
		set_regs(tla_pkg::MODE_UNUSED, 32'd0);
		push_entry(32'h0000_0010, 32'd3, 32'd0, 1'b0);
		push_entry(32'h0000_0020, 32'd1, 32'd2, 1'b1);

		phase = 0;
		while (items_sent < 750) begin
			set_regs(2'($urandom_range(0, 3)), draw_tolerance());
			gap_level = $urandom_range(0, 3);
			stall_level = $urandom_range(0, 3);
			if (phase == 2)
				send_set(tla_pkg::MAX_ENTRIES, 1'b1);
			else if (phase == 5)
				send_set(tla_pkg::MAX_ENTRIES + $urandom_range(1, 4), 1'b0);
			else
				repeat ($urandom_range(2, 6))
					send_set(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) :
						$urandom_range(1, 12), 1'b0);
			phase++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
rtl/tla_pkg.sv
rtl/tla_store.sv
rtl/tla_scan.sv
rtl/tolerant_lexicographic_argmin.sv
rtl/tla_checker.sv
test/argmin_checker.sv
test/tolerant_lexicographic_argmin_tb.sv
